// ----- rtl/jfmd_pkg.sv -----
`timescale 1ns / 1ps

package jfmd_pkg;

    // frame position codes
    localparam logic [3:0] POS_IDLE   = 4'd0;
    localparam logic [3:0] POS_FIRST  = 4'd1;
    localparam logic [3:0] POS_X_LAST = 4'd4;
    localparam logic [3:0] POS_Y_LAST = 4'd8;
    localparam logic [3:0] POS_LAST   = 4'd10;

    localparam logic [7:0]  HEADER_RESET  = 8'd97;
    localparam logic [15:0] ASCII_ZERO    = 16'd48;
    localparam logic [16:0] CENTRE_OFFSET = 17'd2047;
    localparam logic [16:0] RESCALE_DIV   = 17'd4093;
    localparam logic [15:0] SPEED_OFFSET  = 16'd13;

    localparam logic [15:0] DEAD_LO  = 16'd1946;
    localparam logic [15:0] DEAD_HI  = 16'd2150;
    localparam logic [15:0] MID      = 16'd2048;
    localparam logic [15:0] MID_LOW  = 16'd2047;
    localparam logic [15:0] FULL     = 16'd4095;

    // floor(p / 25) = (p * RECIP_25) >> RECIP_SHIFT for any 32-bit p
    localparam logic [31:0] RECIP_25    = 32'd1374389535;
    localparam int          RECIP_SHIFT = 35;

    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_A    = 2'd1,
        SEL_B    = 2'd2
    } duty_sel_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] s;
    } frame_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] sp;
    } scaled_t;

    typedef struct packed {
        logic [15:0]         ta;
        logic [15:0]         tb;
        logic [15:0]         sp;
        duty_sel_t [3:0]     sel;   // 0 FL, 1 FR, 2 BL, 3 BR
        logic                hold;
    } terms_t;

    typedef logic [3:0][15:0] duty_vec_t;

endpackage

// ----- rtl/joystick_frame_to_four_motor_duty.sv -----
`timescale 1ns / 1ps

// Joystick frame decoder driving four wheel PWM compare values.
// Input channel (in_valid/in_ready/rx_byte): one received byte per transfer.
// Bytes are dropped until one equals header_byte; the next ten bytes are taken
// as ASCII digits (four X, four Y, two speed). The tenth byte closes the frame.
// Output channel (out_valid/out_ready): one transfer of four duties per frame.
// Config channel (cfg_valid/cfg_ready/header_byte): always ready, write only
// while the block is idle. header_byte resets to 97 ('a').
// The closing byte passes through the frame register, two rescale stages,
// region decode, multiply, then the divide-by-25 multiply into the output
// register, which raises out_valid.
// Throughput: one byte per cycle; each stage has its own valid bit, so bytes
// keep flowing while a result waits on a stalled receiver until the stages
// behind the output register fill up, then in_ready drops.
// Reset: frame parser waits for a header, accumulators and held duties are 0,
// no result pending. A frame landing in a deadband edge repeats the duties held.
module joystick_frame_to_four_motor_duty (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  header_byte,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] front_left_duty,
    output logic [15:0] front_right_duty,
    output logic [15:0] back_left_duty,
    output logic [15:0] back_right_duty
);
    import jfmd_pkg::*;

    logic      job_valid, job_ready;
    frame_t    job;
    logic      scaled_valid, scaled_ready;
    scaled_t   scaled;
    logic      terms_valid, terms_ready;
    terms_t    terms;
    duty_vec_t duty;

    jfmd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .header_byte (header_byte),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job)
    );

    jfmd_rescale u_rescale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (job_valid),
        .in_ready  (job_ready),
        .in_job    (job),
        .out_valid (scaled_valid),
        .out_ready (scaled_ready),
        .out_job   (scaled)
    );

    jfmd_region u_region (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scaled_valid),
        .in_ready  (scaled_ready),
        .in_job    (scaled),
        .out_valid (terms_valid),
        .out_ready (terms_ready),
        .out_job   (terms)
    );

    jfmd_duty u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (terms_valid),
        .in_ready  (terms_ready),
        .in_job    (terms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .duty      (duty)
    );

    assign front_left_duty  = duty[0];
    assign front_right_duty = duty[1];
    assign back_left_duty   = duty[2];
    assign back_right_duty  = duty[3];

endmodule

// ----- rtl/jfmd_frame.sv -----
`timescale 1ns / 1ps

module jfmd_frame (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      header_byte,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      rx_byte,
    output logic            job_valid,
    input  logic            job_ready,
    output jfmd_pkg::frame_t job
);
    import jfmd_pkg::*;

    logic [7:0]  header_reg, header_next;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] x_acc_reg, x_acc_next;
    logic [15:0] y_acc_reg, y_acc_next;
    logic [15:0] s_acc_reg, s_acc_next;
    logic        job_valid_reg, job_valid_next;
    frame_t      job_reg, job_next;
    logic        in_fire;
    logic [15:0] digit;

    function automatic logic [15:0] push_digit(input logic [15:0] acc, input logic [15:0] d);
        push_digit = {acc[12:0], 3'b000} + {acc[14:0], 1'b0} + d;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = !job_valid_reg || job_ready;
    assign in_fire   = in_valid && in_ready;
    assign digit     = {8'b0, rx_byte} - ASCII_ZERO;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        header_next    = cfg_valid ? header_byte : header_reg;
        pos_next       = pos_reg;
        x_acc_next     = x_acc_reg;
        y_acc_next     = y_acc_reg;
        s_acc_next     = s_acc_reg;
        job_next       = job_reg;
        job_valid_next = in_ready ? 1'b0 : job_valid_reg;
        if (in_fire)
        begin
            if (pos_reg == POS_IDLE || pos_reg > POS_LAST)
            begin
                pos_next = (rx_byte == header_reg) ? POS_FIRST : POS_IDLE;
            end
            else if (pos_reg <= POS_X_LAST)
            begin
                x_acc_next = push_digit(x_acc_reg, digit);
                pos_next   = pos_reg + 4'd1;
            end
            else if (pos_reg <= POS_Y_LAST)
            begin
                y_acc_next = push_digit(y_acc_reg, digit);
                pos_next   = pos_reg + 4'd1;
            end
            else if (pos_reg < POS_LAST)
            begin
                s_acc_next = push_digit(s_acc_reg, digit);
                pos_next   = pos_reg + 4'd1;
            end
            else
            begin
                // last speed digit closes the frame
                job_next.x     = x_acc_reg;
                job_next.y     = y_acc_reg;
                job_next.s     = push_digit(s_acc_reg, digit);
                job_valid_next = 1'b1;
                x_acc_next     = '0;
                y_acc_next     = '0;
                s_acc_next     = '0;
                pos_next       = POS_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= HEADER_RESET;
            pos_reg       <= POS_IDLE;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            s_acc_reg     <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            header_reg    <= header_next;
            pos_reg       <= pos_next;
            x_acc_reg     <= x_acc_next;
            y_acc_reg     <= y_acc_next;
            s_acc_reg     <= s_acc_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("frame position out of range");

    a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && pos_reg == POS_LAST |=>
            pos_reg == POS_IDLE && job_valid_reg && x_acc_reg == '0 &&
            y_acc_reg == '0 && s_acc_reg == '0)
        else $error("frame close did not clear accumulators or raise job");

    a_stay_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && pos_reg == POS_IDLE && rx_byte != header_reg |=> pos_reg == POS_IDLE)
        else $error("left idle on a non-header byte");

endmodule

// ----- rtl/jfmd_rescale.sv -----
`timescale 1ns / 1ps

module jfmd_rescale (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  jfmd_pkg::frame_t  in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output jfmd_pkg::scaled_t out_job
);
    import jfmd_pkg::*;

    // first stage: sign and magnitude of v - 2047
    logic        a_valid_reg, a_valid_next;
    logic        a_xneg_reg, a_yneg_reg;
    logic [15:0] a_xmag_reg, a_ymag_reg, a_sp_reg;
    logic [16:0] xsm, ysm;
    logic        b_valid_reg, b_valid_next;
    scaled_t     b_reg;
    logic        a_load_ok, b_load_ok;

    function automatic logic [16:0] sign_mag(input logic [15:0] v);
        logic [16:0] d;
        d = {1'b0, v} - CENTRE_OFFSET;
        sign_mag = d[16] ? {1'b1, 16'(17'd0 - d)} : {1'b0, d[15:0]};
    endfunction

    // d*4095/4093 = d + 2d/4093; the quotient 2|d|/4093 is small and sits at
    // 2|d|>>12 or one above it
    function automatic logic [15:0] finish(input logic [15:0] mag, input logic neg);
        logic [16:0] m;
        logic [4:0]  q0;
        logic [16:0] prod;
        logic [16:0] r;
        logic [5:0]  f;
        logic [15:0] sum;
        m    = {mag, 1'b0};
        q0   = m[16:12];
        prod = {q0, 12'b0} - ({11'b0, q0, 1'b0} + {12'b0, q0});
        r    = m - prod;
        f    = {1'b0, q0} + ((r >= RESCALE_DIV) ? 6'd1 : 6'd0);
        sum  = mag + {10'b0, f};
        finish = neg ? (16'd0 - sum) : sum;
    endfunction

    assign b_load_ok = !b_valid_reg || out_ready;
    assign a_load_ok = !a_valid_reg || b_load_ok;
    assign in_ready  = a_load_ok;
    assign xsm       = sign_mag(in_job.x);
    assign ysm       = sign_mag(in_job.y);
    assign out_valid = b_valid_reg;
    assign out_job   = b_reg;

    always_comb
    begin
        a_valid_next = a_load_ok ? in_valid : a_valid_reg;
        b_valid_next = b_load_ok ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load_ok && in_valid)
        begin
            a_xneg_reg <= xsm[16];
            a_xmag_reg <= xsm[15:0];
            a_yneg_reg <= ysm[16];
            a_ymag_reg <= ysm[15:0];
            a_sp_reg   <= in_job.s - SPEED_OFFSET;
        end
        if (b_load_ok && a_valid_reg)
        begin
            b_reg.x  <= finish(a_xmag_reg, a_xneg_reg);
            b_reg.y  <= finish(a_ymag_reg, a_yneg_reg);
            b_reg.sp <= a_sp_reg;
        end
    end

endmodule

// ----- rtl/jfmd_region.sv -----
`timescale 1ns / 1ps

module jfmd_region (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  jfmd_pkg::scaled_t in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output jfmd_pkg::terms_t  out_job
);
    import jfmd_pkg::*;

    logic        valid_reg, valid_next;
    terms_t      terms_reg, terms_next;
    logic [15:0] x, y, mx, my;

    assign x         = in_job.x;
    assign y         = in_job.y;
    assign mx        = FULL - x;
    assign my        = FULL - y;
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_job   = terms_reg;

    always_comb
    begin
        terms_next.ta   = '0;
        terms_next.tb   = '0;
        terms_next.sp   = in_job.sp;
        terms_next.sel  = {SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO};
        terms_next.hold = 1'b0;
        if (x < DEAD_HI && y < DEAD_HI && x > DEAD_LO && y > DEAD_LO)
        begin
            // centre: all wheels stop
        end
        else if (x <= DEAD_HI && x >= DEAD_LO && y >= DEAD_HI)
        begin
            terms_next.ta  = y - MID;
            terms_next.sel = {SEL_ZERO, SEL_ZERO, SEL_A, SEL_A};
        end
        else if (x <= DEAD_HI && x >= DEAD_LO && y < DEAD_LO)
        begin
            terms_next.ta  = MID_LOW - y;
            terms_next.sel = {SEL_A, SEL_A, SEL_ZERO, SEL_ZERO};
        end
        else if (y > DEAD_LO && y < DEAD_HI && x < DEAD_LO)
        begin
            terms_next.ta  = MID_LOW - x;
            terms_next.sel = {SEL_ZERO, SEL_A, SEL_A, SEL_ZERO};
        end
        else if (y > DEAD_LO && y < DEAD_HI && x > DEAD_HI)
        begin
            terms_next.ta  = x - MID;
            terms_next.sel = {SEL_A, SEL_ZERO, SEL_ZERO, SEL_A};
        end
        else if (x > DEAD_HI && y > DEAD_HI)
        begin
            if (y > x)
            begin
                terms_next.ta  = y - MID;
                terms_next.tb  = y - x;
                terms_next.sel = {SEL_ZERO, SEL_ZERO, SEL_B, SEL_A};
            end
            else
            begin
                terms_next.ta  = x - MID;
                terms_next.tb  = x - y;
                terms_next.sel = {SEL_B, SEL_ZERO, SEL_ZERO, SEL_A};
            end
        end
        else if (x < DEAD_LO && y > DEAD_HI)
        begin
            if (y > mx)
            begin
                terms_next.ta  = y - mx;
                terms_next.tb  = y - MID;
                terms_next.sel = {SEL_ZERO, SEL_ZERO, SEL_B, SEL_A};
            end
            else
            begin
                terms_next.ta  = mx;
                terms_next.tb  = mx - y;
                terms_next.sel = {SEL_ZERO, SEL_B, SEL_A, SEL_ZERO};
            end
        end
        else if (x < DEAD_LO && y < DEAD_LO)
        begin
            if (my > mx)
            begin
                terms_next.ta  = my - MID;
                terms_next.tb  = my - mx;
                terms_next.sel = {SEL_B, SEL_A, SEL_ZERO, SEL_ZERO};
            end
            else
            begin
                terms_next.ta  = mx - my;
                terms_next.tb  = mx - MID;
                terms_next.sel = {SEL_ZERO, SEL_B, SEL_A, SEL_ZERO};
            end
        end
        else if (x > DEAD_HI && y < DEAD_LO)
        begin
            if (my > x)
            begin
                terms_next.ta  = my - x;
                terms_next.tb  = my - MID;
                terms_next.sel = {SEL_B, SEL_A, SEL_ZERO, SEL_ZERO};
            end
            else
            begin
                terms_next.ta  = x - my;
                terms_next.tb  = x - MID;
                terms_next.sel = {SEL_B, SEL_ZERO, SEL_ZERO, SEL_A};
            end
        end
        else
        begin
            // deadband edge: keep what the wheels had
            terms_next.hold = 1'b1;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            terms_reg <= terms_next;
        end
    end

endmodule

// ----- rtl/jfmd_duty.sv -----
`timescale 1ns / 1ps

module jfmd_duty (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  jfmd_pkg::terms_t    in_job,
    output logic                out_valid,
    input  logic                out_ready,
    output jfmd_pkg::duty_vec_t duty
);
    import jfmd_pkg::*;

    logic            p_valid_reg, p_valid_next;
    logic [31:0]     pa_reg, pb_reg;
    duty_sel_t [3:0] p_sel_reg;
    logic            p_hold_reg;
    logic            out_valid_reg, out_valid_next;
    duty_vec_t       duty_reg, duty_next;
    logic            out_load_ok;
    logic [63:0]     qa_full, qb_full;
    logic [15:0]     qa, qb;

    assign out_load_ok = !out_valid_reg || out_ready;
    assign in_ready    = !p_valid_reg || out_load_ok;
    assign out_valid   = out_valid_reg;
    assign duty        = duty_reg;

    // divide by 25 through the reciprocal, keep the low 16 bits of the quotient
    assign qa_full = pa_reg * RECIP_25;
    assign qb_full = pb_reg * RECIP_25;
    assign qa      = qa_full[RECIP_SHIFT +: 16];
    assign qb      = qb_full[RECIP_SHIFT +: 16];

    always_comb
    begin
        p_valid_next   = in_ready ? in_valid : p_valid_reg;
        out_valid_next = out_load_ok ? p_valid_reg : out_valid_reg;
        duty_next      = duty_reg;
        if (out_load_ok && p_valid_reg && !p_hold_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                case (p_sel_reg[k])
                    SEL_A:    duty_next[k] = qa;
                    SEL_B:    duty_next[k] = qb;
                    SEL_ZERO: duty_next[k] = '0;
                    default:  duty_next[k] = '0;
                endcase
            end
        end
    end

    // the output register doubles as the held duties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            duty_reg      <= '0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
            duty_reg      <= duty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pa_reg     <= in_job.ta * in_job.sp;
            pb_reg     <= in_job.tb * in_job.sp;
            p_sel_reg  <= in_job.sel;
            p_hold_reg <= in_job.hold;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import jfmd_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 220;

    localparam int AXIS_CENTRE = 2047;
    localparam int GAIN_NUM    = 4095;
    localparam int GAIN_DEN    = 4093;
    localparam int DUTY_DIV    = 25;

    // Tracks the frame parser and the held duties, and keeps the duty sets still owed.
    class wheel_duty_tracker;
        logic [7:0]  header;
        logic [3:0]  position;
        logic [15:0] x_acc;
        logic [15:0] y_acc;
        logic [15:0] s_acc;
        duty_vec_t   held;
        duty_vec_t   expected_duties[$];
        int          errors;

        function new();
            header   = HEADER_RESET;
            position = POS_IDLE;
            x_acc    = '0;
            y_acc    = '0;
            s_acc    = '0;
            held     = '0;
            errors   = 0;
        endfunction

        function logic [15:0] next_digit(logic [15:0] acc, logic [7:0] b);
            return acc * 16'd10 + ({8'd0, b} - ASCII_ZERO);
        endfunction

        // signed rescale, C-style truncation toward zero, wrapped to 16 bits
        function logic [15:0] rescale_axis(logic [15:0] v);
            int d;
            d = (int'(v) - AXIS_CENTRE) * GAIN_NUM;
            return 16'(d / GAIN_DEN);
        endfunction

        function logic [15:0] scale_duty(logic [31:0] term, logic [15:0] spd);
            logic [31:0] p;
            p = {16'd0, term[15:0]} * {16'd0, spd};
            return 16'(p / DUTY_DIV);
        endfunction

        function void set_wheels(logic [15:0] fl, logic [15:0] fr,
                                 logic [15:0] bl, logic [15:0] br);
            held[0] = fl;
            held[1] = fr;
            held[2] = bl;
            held[3] = br;
        endfunction

        function void decode_regions(logic [31:0] x, logic [31:0] y, logic [15:0] z);
            logic [31:0] mx;
            logic [31:0] my;
            logic [15:0] d;
            mx = FULL - x;
            my = FULL - y;
            if (x < DEAD_HI && y < DEAD_HI && x > DEAD_LO && y > DEAD_LO)
                set_wheels('0, '0, '0, '0);
            else if (x <= DEAD_HI && x >= DEAD_LO && y >= DEAD_HI)
            begin
                d = scale_duty(y - MID, z);
                set_wheels(d, d, '0, '0);
            end
            else if (x <= DEAD_HI && x >= DEAD_LO && y < DEAD_LO)
            begin
                d = scale_duty(MID_LOW - y, z);
                set_wheels('0, '0, d, d);
            end
            else if (y > DEAD_LO && y < DEAD_HI && x < DEAD_LO)
            begin
                d = scale_duty(MID_LOW - x, z);
                set_wheels('0, d, d, '0);
            end
            else if (y > DEAD_LO && y < DEAD_HI && x > DEAD_HI)
            begin
                d = scale_duty(x - MID, z);
                set_wheels(d, '0, '0, d);
            end
            else if (x > DEAD_HI && y > DEAD_HI)
            begin
                if (y > x)
                    set_wheels(scale_duty(y - MID, z), scale_duty(y - x, z), '0, '0);
                else
                    set_wheels(scale_duty(x - MID, z), '0, '0, scale_duty(x - y, z));
            end
            else if (x < DEAD_LO && y > DEAD_HI)
            begin
                if (y > mx)
                    set_wheels(scale_duty(y - mx, z), scale_duty(y - MID, z), '0, '0);
                else
                    set_wheels('0, scale_duty(mx, z), scale_duty(mx - y, z), '0);
            end
            else if (x < DEAD_LO && y < DEAD_LO)
            begin
                if (my > mx)
                    set_wheels('0, '0, scale_duty(my - MID, z), scale_duty(my - mx, z));
                else
                    set_wheels('0, scale_duty(mx - my, z), scale_duty(mx - MID, z), '0);
            end
            else if (x > DEAD_HI && y < DEAD_LO)
            begin
                if (my > x)
                    set_wheels('0, '0, scale_duty(my - x, z), scale_duty(my - MID, z));
                else
                    set_wheels(scale_duty(x - my, z), '0, '0, scale_duty(x - MID, z));
            end
            // no region: held duties stand
        endfunction

        function void take_byte(logic [7:0] b);
            if (position == POS_IDLE || position > POS_LAST)
            begin
                position = (b == header) ? POS_FIRST : POS_IDLE;
                return;
            end
            if (position <= POS_X_LAST)
                x_acc = next_digit(x_acc, b);
            else if (position <= POS_Y_LAST)
                y_acc = next_digit(y_acc, b);
            else
                s_acc = next_digit(s_acc, b);
            if (position < POS_LAST)
            begin
                position = position + 4'd1;
                return;
            end
            decode_regions({16'd0, rescale_axis(x_acc)}, {16'd0, rescale_axis(y_acc)},
                           s_acc - SPEED_OFFSET);
            x_acc    = '0;
            y_acc    = '0;
            s_acc    = '0;
            position = POS_IDLE;
            expected_duties.push_back(held);
        endfunction

        function void compare_duties(duty_vec_t got);
            string     wheel_name[4] = '{"front_left_duty", "front_right_duty",
                                         "back_left_duty", "back_right_duty"};
            duty_vec_t want;
            if (expected_duties.size() == 0)
            begin
                $error("unexpected duty transfer: FL %0d FR %0d BL %0d BR %0d",
                       got[0], got[1], got[2], got[3]);
                errors++;
                return;
            end
            want = expected_duties.pop_front();
            for (int k = 0; k < 4; k++)
            begin
                if (got[k] !== want[k])
                begin
                    $error("%s: expected %0d, actual %0d", wheel_name[k], want[k], got[k]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [7:0]  header_byte = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte     = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [15:0] front_left_duty;
    logic [15:0] front_right_duty;
    logic [15:0] back_left_duty;
    logic [15:0] back_right_duty;

    wheel_duty_tracker wheels;
    logic [7:0]        cur_header = HEADER_RESET;
    logic [7:0]        frame_body [10];
    bit                in_burst   = 1'b0;
    bit                out_burst  = 1'b0;
    int                counted    = 0;

    joystick_frame_to_four_motor_duty u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .header_byte      (header_byte),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .front_left_duty  (front_left_duty),
        .front_right_duty (front_right_duty),
        .back_left_duty   (back_left_duty),
        .back_right_duty  (back_right_duty)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        wheels.take_byte(b);
    endtask

    task automatic send_frame(int len);
        send_byte(cur_header);
        for (int k = 0; k < len; k++)
            send_byte(frame_body[k]);
        counted += len + 1;
    endtask

    function automatic void fill_digits(int start, int value, int ndig);
        for (int k = ndig - 1; k >= 0; k--)
        begin
            frame_body[start + k] = ASCII_ZERO[7:0] + 8'(value % 10);
            value = value / 10;
        end
    endfunction

    // raw axis value aimed at one band of the rescaled range
    function automatic int pick_axis();
        int edges[9] = '{3992, 3993, 3994, 4195, 4196, 4197, 2047, 6140, 6142};
        case ($urandom_range(0, 5))
            0:       return $urandom_range(3993, 4196);
            1:       return $urandom_range(2047, 3992);
            2:       return $urandom_range(4197, 6142);
            3:       return edges[$urandom_range(0, 8)];
            4:       return $urandom_range(0, 2046);
            default: return $urandom_range(0, 9999);
        endcase
    endfunction

    function automatic int pick_speed();
        int edges[5] = '{0, 12, 13, 14, 99};
        if ($urandom_range(0, 9) == 0)
            return edges[$urandom_range(0, 4)];
        return $urandom_range(0, 99);
    endfunction

    function automatic logic [7:0] non_header_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == cur_header);
        return b;
    endfunction

    task automatic random_frame();
        int kind;
        int n;
        kind     = $urandom_range(0, 19);
        in_burst = ($urandom_range(0, 3) == 0);
        fill_digits(0, pick_axis(), 4);
        fill_digits(4, pick_axis(), 4);
        fill_digits(8, pick_speed(), 2);
        if (kind < 13)
            send_frame(10);
        else if (kind < 15)
        begin
            for (int k = 0; k < 10; k++)
                if ($urandom_range(0, 2) == 0)
                    frame_body[k] = 8'($urandom_range(0, 255));
            send_frame(10);
        end
        else if (kind < 17)
            send_frame($urandom_range(0, 9));   // cut short: next bytes get absorbed
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(non_header_byte());
            counted += n;
        end
    endtask

    task automatic write_header(logic [7:0] v);
        in_valid <= 1'b0;
        while (wheels.expected_duties.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid   <= 1'b1;
        header_byte <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid     <= 1'b0;
        wheels.header  = v;
        cur_header     = v;
    endtask

    // receiver: fresh stall drawn before each result transfer
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            wheels.compare_duties({back_right_duty, back_left_duty,
                                   front_right_duty, front_left_duty});
    end

    initial
    begin
        logic [7:0] header_plan[5];
        wheels = new();
        header_plan = '{8'h00, 8'hFF, 8'h35, 8'($urandom_range(0, 255)), HEADER_RESET};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: stray bytes, extreme digits, then a frame on the deadband corner
        send_byte(8'h00);
        send_byte(8'hFF);
        fill_digits(0, 9999, 4);
        fill_digits(4, 0, 4);
        fill_digits(8, 99, 2);
        send_frame(10);
        fill_digits(0, 3993, 4);
        fill_digits(4, 3993, 4);
        fill_digits(8, 50, 2);
        send_frame(10);

        foreach (header_plan[p])
        begin
            write_header(header_plan[p]);
            out_burst = ($urandom_range(0, 3) == 0);
            counted   = 0;
            while (counted < PHASE_ITEMS)
                random_frame();
        end

        in_valid <= 1'b0;
        while (wheels.expected_duties.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (wheels.errors == 0)
            $display("joystick_frame_to_four_motor_duty: match");
        else
            $display("joystick_frame_to_four_motor_duty: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("joystick_frame_to_four_motor_duty: mismatch");
        $finish;
    end

endmodule
